// ===== hw/rtl/rrs_pkg.sv =====
`default_nettype none
package rrs_pkg;

  localparam int SqStages  = 32;
  localparam int DivStages = 31;
  localparam logic [31:0] MinDist = 32'd66;

  localparam logic [1:0] CFG_PUSH_STRENGTH    = 2'd0;
  localparam logic [1:0] CFG_INFLUENCE_RADIUS = 2'd1;

  localparam logic [30:0] PushReset   = 31'd65536;
  localparam logic [30:0] RadiusReset = 31'd655360;

  typedef struct packed {
    logic              valid;
    logic              push;
    logic [2:0]        neg;
    logic [2:0][31:0]  own;
    logic [2:0][30:0]  m;
    logic [30:0]       len;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rrs_isqrt.sv =====
`default_nettype none
module rrs_isqrt (
  input  wire logic        clk,
  input  wire logic [63:0] sum,
  output logic      [31:0] root
);
  import rrs_pkg::*;

  logic [63:0] rem_q  [0:SqStages];
  logic [63:0] root_q [0:SqStages];

  assign rem_q[0]  = sum;
  assign root_q[0] = '0;

  for (genvar k = 0; k < SqStages; k++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = root_q[k] + Bit;
    assign ge    = rem_q[k] >= trial;
    always_ff @(posedge clk) begin
      rem_q[k+1]  <= ge ? rem_q[k] - trial : rem_q[k];
      root_q[k+1] <= ge ? (root_q[k] >> 1) + Bit : root_q[k] >> 1;
    end
  end

  assign root = root_q[SqStages][31:0];

endmodule
`default_nettype wire

// ===== hw/rtl/rrs_div.sv =====
`default_nettype none
module rrs_div (
  input  wire logic        clk,
  input  wire logic [61:0] num,
  input  wire logic [30:0] den,
  output logic      [30:0] quo
);
  import rrs_pkg::*;

  // quotient assumed below 2^31 (upper half of num below den)
  logic [30:0] r_q  [0:DivStages];
  logic [30:0] lo_q [0:DivStages];
  logic [30:0] d_q  [0:DivStages];
  logic [30:0] q_q  [0:DivStages];

  assign r_q[0]  = num[61:31];
  assign lo_q[0] = num[30:0];
  assign d_q[0]  = den;
  assign q_q[0]  = '0;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [31:0] t;
    logic [31:0] diff;
    logic        ge;
    assign t    = {r_q[k], lo_q[k][30]};
    assign diff = t - {1'b0, d_q[k]};
    assign ge   = t >= {1'b0, d_q[k]};
    always_ff @(posedge clk) begin
      r_q[k+1]  <= ge ? diff[30:0] : t[30:0];
      lo_q[k+1] <= {lo_q[k][29:0], 1'b0};
      d_q[k+1]  <= d_q[k];
      q_q[k+1]  <= {q_q[k][29:0], ge};
    end
  end

  assign quo = q_q[DivStages];

endmodule
`default_nettype wire

// ===== hw/rtl/radial_repulsion_step.sv =====
`default_nettype none
// Pushes a 3D Q16.16 point away from a target. One item can start every cycle
// (busy stays low); its result appears with a one-cycle done strobe, in order,
// after the item passes the 32-stage square root and two 31-stage dividers in
// series. The result cannot be held off and must be captured in the cycle done
// is high. Configuration writes are taken at any time (cfg_ready is always
// high) and must happen while no item is in flight.
module radial_repulsion_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] own_x,
  input  wire logic signed [31:0] own_y,
  input  wire logic signed [31:0] own_z,
  input  wire logic signed [31:0] other_x,
  input  wire logic signed [31:0] other_y,
  input  wire logic signed [31:0] other_z,
  output logic             done,
  output logic signed [31:0] next_x,
  output logic signed [31:0] next_y,
  output logic signed [31:0] next_z,
  output logic             pushed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rrs_pkg::*;

  logic [30:0] push_strength;
  logic [30:0] influence_radius;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_strength    <= PushReset;
      influence_radius <= RadiusReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PUSH_STRENGTH:    push_strength    <= cfg_data[30:0];
        CFG_INFLUENCE_RADIUS: influence_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // stage 1: offsets
  logic [2:0][31:0] own_in;
  logic [2:0][31:0] oth_in;
  side_t s1_next;
  side_t s1;

  assign own_in = {own_z, own_y, own_x};
  assign oth_in = {other_z, other_y, other_x};

  always_comb begin
    logic signed [32:0] d;
    logic [32:0] mg;
    s1_next       = '0;
    s1_next.valid = start && !busy;
    s1_next.push  = 1'b1;
    s1_next.own   = own_in;
    s1_next.len   = '0;
    for (int i = 0; i < 3; i++) begin
      d  = {own_in[i][31], own_in[i]} - {oth_in[i][31], oth_in[i]};
      mg = d[32] ? 33'(-d) : 33'(d);
      s1_next.neg[i] = d[32];
      s1_next.m[i]   = mg[30:0];
      if (mg > {2'b0, influence_radius}) s1_next.push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1.valid <= 1'b0;
    else     s1 <= s1_next;
  end

  // stage 2: squares
  side_t s2;
  logic [2:0][61:0] sq;
  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else     s2 <= s1;
    for (int i = 0; i < 3; i++) sq[i] <= {31'b0, s1.m[i]} * {31'b0, s1.m[i]};
  end

  // stage 3: square sum
  side_t s3;
  logic [63:0] sum;
  always_ff @(posedge clk) begin
    if (rst) s3.valid <= 1'b0;
    else     s3 <= s2;
    sum <= s2.push ? {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]} : 64'd0;
  end

  logic [31:0] root;
  rrs_isqrt u_isqrt (.clk(clk), .sum(sum), .root(root));

  side_t sa [0:SqStages];
  assign sa[0] = s3;
  for (genvar k = 0; k < SqStages; k++) begin : g_sa
    always_ff @(posedge clk) begin
      if (rst) sa[k+1].valid <= 1'b0;
      else     sa[k+1] <= sa[k];
    end
  end

  // stage 4: range check
  side_t s4;
  logic [30:0] diff;
  always_ff @(posedge clk) begin
    logic ok;
    ok = sa[SqStages].push && (root >= MinDist) && (root <= {1'b0, influence_radius});
    if (rst) s4.valid <= 1'b0;
    else begin
      s4      <= sa[SqStages];
      s4.push <= ok;
      s4.len  <= ok ? root[30:0] : 31'd1;
    end
    diff <= ok ? influence_radius - root[30:0] : 31'd0;
  end

  // stage 5: strength times remaining distance
  side_t s5;
  logic [61:0] mul;
  always_ff @(posedge clk) begin
    if (rst) s5.valid <= 1'b0;
    else     s5 <= s4;
    mul <= {31'b0, push_strength} * {31'b0, diff};
  end

  logic [30:0] speed;
  rrs_div u_div_speed (.clk(clk), .num(mul), .den(influence_radius), .quo(speed));

  side_t sb [0:DivStages];
  assign sb[0] = s5;
  for (genvar k = 0; k < DivStages; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (rst) sb[k+1].valid <= 1'b0;
      else     sb[k+1] <= sb[k];
    end
  end

  // stage 6: per-axis products
  side_t s6;
  logic [2:0][61:0] prod;
  always_ff @(posedge clk) begin
    if (rst) s6.valid <= 1'b0;
    else     s6 <= sb[DivStages];
    for (int i = 0; i < 3; i++) prod[i] <= {31'b0, sb[DivStages].m[i]} * {31'b0, speed};
  end

  logic [2:0][30:0] quo;
  for (genvar i = 0; i < 3; i++) begin : g_axis
    rrs_div u_div_axis (.clk(clk), .num(prod[i]), .den(s6.len), .quo(quo[i]));
  end

  side_t sc [0:DivStages];
  assign sc[0] = s6;
  for (genvar k = 0; k < DivStages; k++) begin : g_sc
    always_ff @(posedge clk) begin
      if (rst) sc[k+1].valid <= 1'b0;
      else     sc[k+1] <= sc[k];
    end
  end

  // stage 7: apply and saturate
  logic [2:0][31:0] res;
  always_comb begin
    logic signed [33:0] v;
    logic signed [33:0] p;
    for (int i = 0; i < 3; i++) begin
      p = sc[DivStages].neg[i] ? -$signed({3'b0, quo[i]}) : $signed({3'b0, quo[i]});
      v = $signed({{2{sc[DivStages].own[i][31]}}, sc[DivStages].own[i]}) + p;
      if (!sc[DivStages].push)             res[i] = sc[DivStages].own[i];
      else if (v > 34'sd2147483647)        res[i] = 32'h7fff_ffff;
      else if (v < -34'sd2147483648)       res[i] = 32'h8000_0000;
      else                                 res[i] = v[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      pushed <= 1'b0;
    end else begin
      done   <= sc[DivStages].valid;
      pushed <= sc[DivStages].valid && sc[DivStages].push;
    end
    next_x <= res[0];
    next_y <= res[1];
    next_z <= res[2];
  end

  a_pushed_done: assert property (@(posedge clk) disable iff (rst) pushed |-> done)
    else $error("pushed without done");
  a_min_dist: assert property (@(posedge clk) disable iff (rst)
    s4.valid && s4.push |-> {1'b0, s4.len} >= MinDist)
    else $error("push below minimum distance");
  a_idle_mul: assert property (@(posedge clk) disable iff (rst)
    s5.valid && !s5.push |-> mul == 62'd0)
    else $error("nonzero strength product on pass-through item");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
  import rrs_pkg::*;

  localparam int Latency = 101;
  localparam int WatchLimit = 2000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pushed;
  } move_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [31:0] own_x = '0, own_y = '0, own_z = '0;
  logic signed [31:0] other_x = '0, other_y = '0, other_z = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = CFG_PUSH_STRENGTH;
  logic [31:0] cfg_data = '0;
  wire busy, done, pushed, cfg_ready;
  wire signed [31:0] next_x, next_y, next_z;

  radial_repulsion_step DUT (.*);

  always #5 clk = ~clk;

  logic [30:0] strength_q;
  logic [30:0] radius_q;
  move_t expected_moves[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] s);
    logic [63:0] rem, root, bt;
    rem = s; root = 0; bt = 64'd1 << 62;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= root + bt) begin
        rem = rem - (root + bt);
        root = (root >> 1) + bt;
      end else begin
        root >>= 1;
      end
      bt >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic move_t repel(input logic signed [31:0] o[3],
                                  input logic signed [31:0] t[3]);
    move_t r;
    logic signed [63:0] d[3];
    logic [63:0] m[3], res[3];
    logic [63:0] sum, len, speed, p;
    logic go;
    go = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(o[i]) - 64'(t[i]);
      m[i] = d[i] < 0 ? -d[i] : d[i];
      res[i] = 64'(o[i]);
      if (m[i] > radius_q) go = 1'b0;
    end
    if (go) begin
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = root_floor(sum);
      if (len < 64'(MinDist) || len > radius_q) begin
        go = 1'b0;
      end else begin
        speed = 64'(strength_q) * (64'(radius_q) - len) / 64'(radius_q);
        for (int i = 0; i < 3; i++) begin
          p = m[i] * speed / len;
          res[i] = d[i] < 0 ? 64'(o[i]) - p : 64'(o[i]) + p;
        end
      end
    end
    r.x = clip32(res[0]);
    r.y = clip32(res[1]);
    r.z = clip32(res[2]);
    r.pushed = go;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    move_t want;
    if (!rst && done) begin
      if (expected_moves.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %h %b",
                                   next_x, next_y, next_z, pushed);
      end else begin
        want = expected_moves.pop_front();
        if (next_x !== want.x || next_y !== want.y || next_z !== want.z ||
            pushed !== want.pushed) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b", want.x, want.y,
                     want.z, want.pushed, next_x, next_y, next_z, pushed);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PUSH_STRENGTH) strength_q = val[30:0];
    else if (idx == CFG_INFLUENCE_RADIUS) radius_q = val[30:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // entered at a falling edge; drops start and returns at a falling edge
  task automatic drain();
    start <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
    @(negedge clk);
  endtask

  // entered at a falling edge; returns at the falling edge after the accept
  // with start still high, so the next item can follow with no gap
  task automatic send_item(input logic signed [31:0] o[3],
                           input logic signed [31:0] t[3]);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    own_x <= o[0]; own_y <= o[1]; own_z <= o[2];
    other_x <= t[0]; other_y <= t[1]; other_z <= t[2];
    do @(posedge clk); while (busy);
    expected_moves.push_back(repel(o, t));
    @(negedge clk);
  endtask

  task automatic send_near(input int spread);
    logic signed [31:0] o[3], t[3];
    for (int i = 0; i < 3; i++) begin
      o[i] = $urandom;
      t[i] = o[i] + $signed($urandom_range(2 * spread)) - spread;
    end
    send_item(o, t);
  endtask

  task automatic test_directed();
    logic signed [31:0] o[3], t[3];
    logic signed [31:0] ext[4] = '{32'sh7fffffff, 32'sh80000000, 0, -1};
    foreach (ext[a]) foreach (ext[b]) begin
      o = '{ext[a], ext[b], ext[a]};
      t = '{ext[b], ext[a], ext[b]};
      send_item(o, t);
    end
    o = '{0, 0, 0};
    t = '{65, 0, 0}; send_item(o, t);   // just too close
    t = '{66, 0, 0}; send_item(o, t);   // minimum distance
    t = '{655360, 0, 0}; send_item(o, t); // exactly at radius
    t = '{655361, 0, 0}; send_item(o, t); // just outside
    o = '{32'sh7fffff00, 32'sh80000100, 0};
    t = '{32'sh7fffff00 - 100, 32'sh80000100 + 100, 0};
    send_item(o, t);                    // saturating push
  endtask

  task automatic test_random(input int n, input int sidle);
    send_idle_pct = sidle;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: send_near(200);
        1, 2: send_near(radius_q > 0 && radius_q < 32'h3fffffff ? int'(radius_q) : 1000000);
        default: send_near(32'h3fffffff);
      endcase
    end
    send_idle_pct = 0;
  endtask

  task automatic test_configs();
    write_reg(CFG_PUSH_STRENGTH, 32'h7fffffff);
    write_reg(CFG_INFLUENCE_RADIUS, 32'h7fffffff);
    test_random(120, 20);
    drain();
    write_reg(CFG_PUSH_STRENGTH, 32'h0);
    write_reg(CFG_INFLUENCE_RADIUS, 32'h0);
    test_random(40, 0);
    drain();
    write_reg(CFG_PUSH_STRENGTH, 32'hffffffff);
    write_reg(CFG_INFLUENCE_RADIUS, 32'h80001000);
    write_reg(2'd3, 32'h12345678);
    test_random(120, 50);
    drain();
    write_reg(CFG_PUSH_STRENGTH, $urandom);
    write_reg(CFG_INFLUENCE_RADIUS, $urandom_range(32'h0fffffff));
    test_random(120, 0);
    drain();
  endtask

  initial begin
    strength_q = PushReset;
    radius_q = RadiusReset;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250, 20);
    drain();
    test_configs();
    write_reg(CFG_PUSH_STRENGTH, PushReset);
    write_reg(CFG_INFLUENCE_RADIUS, RadiusReset);
    test_random(250, 50);
    test_random(250, 0);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
